FILE: rtl/ordered_list_insert_delete_search_core_macros.svh
// Assertion helpers for the ordered list core.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define OLIDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OLIDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/olids_pkg.sv
package olids_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 5;
    localparam int VW    = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_UNUSED = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_INSERTED       = 3'd0,
        ST_DELETED        = 3'd1,
        ST_DEL_MISSING    = 3'd2,
        ST_FOUND          = 3'd3,
        ST_SEARCH_MISSING = 3'd4,
        ST_REJECTED       = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]           command;
        logic signed [VW-1:0] value;
        logic [CW-1:0]        position;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]    status;
        logic [CW-1:0] position_res;
        logic [CW-1:0] length;
        logic          last;
    } t_res_word;

endpackage

FILE: rtl/ordered_list_insert_delete_search_core.sv
// Ordered list of up to DEPTH signed 32-bit values held in a one-port-read,
// one-port-write RAM with a registered read, plus a length register.
// A command word is taken on a rising edge where start is high and busy is
// low; it carries the command, the value and a 1-based insert position.
// Results leave on o_res, each valid for exactly one cycle while o_strobe is
// high; the receiver cannot hold them off, so no result ever waits.
// Insert moves the entries at positions pos..length up one slot, one read
// and one write per cycle, then writes the new value; a value that goes
// on the tail is written with nothing moved.
// Delete scans from the head, one entry per cycle, until the first match,
// then moves the tail down the same way.
// Search scans the whole list and sends one word per match, in ascending
// position order, the final one flagged last.
// A rejected insert or unused command answers the cycle after acceptance.
// Every result word is registered and leaves in the cycle after the state
// that produced it; busy drops at the edge that sends the final word. The
// pace is set by the single RAM read port, which sees one entry per cycle.
// Reset clears the length, the sequencer and the strobe; the RAM is not
// cleared, since only entries below the length are ever read.
module ordered_list_insert_delete_search_core
    import olids_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd_word i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_res_word o_res
);

`include "ordered_list_insert_delete_search_core_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_SCAN = 4'b0100,
        S_SHDN = 4'b1000
    } t_state;

    // Control state.
    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_idx,    n_idx;
    logic          r_pend,   n_pend;
    logic          r_search, n_search;
    logic          r_have,   n_have;
    logic          r_strobe, n_strobe;

    // Payload state.
    logic [VW-1:0] r_val,  n_val;
    logic [CW-1:0] r_pos,  n_pos;
    logic [CW-1:0] r_hpos, n_hpos;
    logic [AW-1:0] r_ra,   n_ra;
    logic [AW-1:0] r_wa,   n_wa;
    t_res_word     r_res,  n_res;

    // RAM port signals.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [VW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    logic          hit;

    olids_ram #(
        .DW(VW),
        .AW(AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // A read issued last cycle has its data on rd_data now.
    assign hit = r_pend && (rd_data == r_val);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_search = r_search;
        n_have   = r_have;
        n_strobe = 1'b0;
        n_val    = r_val;
        n_pos    = r_pos;
        n_hpos   = r_hpos;
        n_ra     = r_ra;
        n_wa     = r_wa;
        n_res    = r_res;
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_wa;
        wr_data  = rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val  = i_cmd.value;
                    n_pos  = i_cmd.position;
                    n_have = 1'b0;
                    n_hpos = '0;
                    case (i_cmd.command)
                        CMD_INSERT: begin
                            if (r_count >= CW'(DEPTH) || i_cmd.position == '0 ||
                                {1'b0, i_cmd.position} > ({1'b0, r_count} + 6'd1)) begin
                                n_strobe = 1'b1;
                                n_res    = '{ST_REJECTED, '0, r_count, 1'b1};
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE: begin
                            n_search = 1'b0;
                            n_idx    = '0;
                            n_state  = S_SCAN;
                        end
                        CMD_SEARCH: begin
                            n_search = 1'b1;
                            n_idx    = '0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res    = '{ST_REJECTED, '0, r_count, 1'b1};
                        end
                    endcase
                end
            end

            S_INS: begin
                // Entry idx-1 moves to idx; the write lands in the cycle after its read,
                // two slots above the read in flight.
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wa;
                    wr_data = rd_data;
                end
                if (r_idx >= r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx - CW'(1));
                    n_pend  = 1'b1;
                    n_wa    = r_idx[AW-1:0];
                    n_idx   = r_idx - CW'(1);
                end else if (!r_pend) begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(r_pos - CW'(1));
                    wr_data  = r_val;
                    n_count  = r_count + CW'(1);
                    n_strobe = 1'b1;
                    n_res    = '{ST_INSERTED, '0, r_count + CW'(1), 1'b1};
                    n_state  = S_IDLE;
                end
            end

            S_SCAN: begin
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_ra    = r_idx[AW-1:0];
                    n_idx   = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (!r_search) begin
                        n_res = '{ST_DEL_MISSING, '0, r_count, 1'b1};
                    end else if (r_have) begin
                        n_res = '{ST_FOUND, r_hpos, r_count, 1'b1};
                    end else begin
                        n_res = '{ST_SEARCH_MISSING, '0, r_count, 1'b1};
                    end
                end
                if (hit) begin
                    if (r_search) begin
                        // Hold the newest match back one step, so that the
                        // final one can still be flagged last.
                        if (r_have) begin
                            n_strobe = 1'b1;
                            n_res    = '{ST_FOUND, r_hpos, r_count, 1'b0};
                        end
                        n_have = 1'b1;
                        n_hpos = {1'b0, r_ra} + CW'(1);
                    end else begin
                        // First match ends the scan; the read in flight is
                        // dropped and the tail shift starts above the match.
                        n_hpos  = {1'b0, r_ra} + CW'(1);
                        n_idx   = {1'b0, r_ra} + CW'(1);
                        n_pend  = 1'b0;
                        n_state = S_SHDN;
                    end
                end
            end

            S_SHDN: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wa;
                    wr_data = rd_data;
                end
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_pend  = 1'b1;
                    n_wa    = AW'(r_idx - CW'(1));
                    n_idx   = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_res    = '{ST_DELETED, r_hpos, r_count - CW'(1), 1'b1};
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_search <= 1'b0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_search <= n_search;
            r_have   <= n_have;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_hpos <= n_hpos;
        r_ra   <= n_ra;
        r_wa   <= n_wa;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // The list never grows past its capacity.
    `OLIDS_ASSERT(a_count_range, r_count <= CW'(DEPTH), "list length beyond capacity")
    // Every result word reports the length that the list now holds.
    `OLIDS_ASSERT(a_len_match, o_strobe |-> o_res.length == r_count, "result length stale")
    // Leaving a command always delivers its final word at the same edge.
    `OLIDS_ASSERT(a_end_last, $fell(busy) |-> o_strobe && o_res.last, "command ended silently")
    // Reads and writes in flight never touch the same entry.
    `OLIDS_ASSERT(a_no_overlap, (rd_en && wr_en) |-> rd_addr != wr_addr, "RAM access overlap")
    // Reset leaves the block idle and silent.
    `OLIDS_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_strobe && !busy, "not quiet after reset")

endmodule

FILE: rtl/olids_ram.sv
module olids_ram #(
    parameter int DW = 32,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: test/tb.sv
// Testbench for the ordered list core.
//
// The initial block plans the whole stimulus up front and puts the command
// words into a queue. The driver takes them from that queue one at a time.
// A planning copy of the list is stepped along with the plan, so that most
// inserts use a legal position and most deletes and searches use a value
// that is really in the list. The length swings between empty and full
// several times.
//
// The driver predicts the answers when the core accepts a word. It works
// on a second copy of the list. The monitor compares every strobed result
// word with the oldest prediction. The receiver cannot stall the core, so
// idling is only on the command side.
module tb;
    import olids_pkg::*;

    localparam int RANDOM_CMDS  = 190;
    localparam int CYCLE_LIMIT  = 200000;
    // The wait scales with the list depth and leaves some margin, enough for
    // the last word of a full-list search to drain.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    // The list contents and the length, as the core should hold them.
    typedef struct {
        logic [VW-1:0] vals [DEPTH];
        int            len;
    } t_list_state;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_cmd_word i_cmd   = '0;
    logic      busy;
    logic      o_strobe;
    t_res_word o_res;

    t_cmd_word   queued_cmds [$];
    t_res_word   awaited_answers [$];
    t_list_state planned_list;
    t_list_state tracked_list;
    logic [VW-1:0] value_pool [5];
    int items_total    = 0;
    int items_accepted = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int idle_left      = 0;
    int steady_left    = 0;

    ordered_list_insert_delete_search_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always #2 i_clk = ~i_clk;

    // Reset is held at the start and then released for the rest of the run.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_res_word answer_word(input logic [2:0] status, input int pos,
                                              input int len, input logic last);
        t_res_word w;
        w.status       = status;
        w.position_res = pos[CW-1:0];
        w.length       = len[CW-1:0];
        w.last         = last;
        return w;
    endfunction

    // Applies one command word to a list and returns the answer words that
    // the core must send for it, in order.
    function automatic void apply_list_command(inout t_list_state st, input t_cmd_word w,
                                               output t_res_word words [$]);
        int        pos;
        int        hit;
        t_res_word tail_word;
        words.delete();
        pos = int'(w.position);
        hit = -1;
        case (w.command)
            CMD_INSERT: begin
                // A full list, position zero and a position past the end
                // all leave the list as it was.
                if (st.len >= DEPTH || pos == 0 || pos > st.len + 1) begin
                    words.push_back(answer_word(ST_REJECTED, 0, st.len, 1'b1));
                end else begin
                    for (int i = st.len; i >= pos; i--) st.vals[i] = st.vals[i-1];
                    st.vals[pos-1] = w.value;
                    st.len++;
                    words.push_back(answer_word(ST_INSERTED, 0, st.len, 1'b1));
                end
            end
            CMD_DELETE: begin
                for (int i = 0; i < st.len; i++) begin
                    if (hit < 0 && st.vals[i] == w.value) hit = i;
                end
                if (hit < 0) begin
                    words.push_back(answer_word(ST_DEL_MISSING, 0, st.len, 1'b1));
                end else begin
                    for (int j = hit; j + 1 < st.len; j++) st.vals[j] = st.vals[j+1];
                    st.len--;
                    words.push_back(answer_word(ST_DELETED, hit + 1, st.len, 1'b1));
                end
            end
            CMD_SEARCH: begin
                for (int i = 0; i < st.len; i++) begin
                    if (st.vals[i] == w.value)
                        words.push_back(answer_word(ST_FOUND, i + 1, st.len, 1'b0));
                end
                if (words.size() == 0) begin
                    words.push_back(answer_word(ST_SEARCH_MISSING, 0, st.len, 1'b1));
                end else begin
                    tail_word = words.pop_back();
                    tail_word.last = 1'b1;
                    words.push_back(tail_word);
                end
            end
            default: begin
                // The spare command code is refused like a bad insert.
                words.push_back(answer_word(ST_REJECTED, 0, st.len, 1'b1));
            end
        endcase
    endfunction

    // Queues one command word and steps the planning copy of the list, so
    // that later picks of positions and values can follow the list.
    task automatic queue_cmd(input logic [1:0] cmd, input logic [VW-1:0] val,
                             input logic [CW-1:0] pos);
        t_cmd_word w;
        t_res_word ignored [$];
        w.command  = cmd;
        w.value    = val;
        w.position = pos;
        apply_list_command(planned_list, w, ignored);
        queued_cmds.push_back(w);
        items_total++;
    endtask

    // Picks a value that is in the list, or one from a small pool so that
    // duplicates are common, or now and then any 32-bit pattern.
    function automatic logic [VW-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && planned_list.len > 0)
            return planned_list.vals[$urandom_range(0, planned_list.len - 1)];
        if (roll < 75)
            return value_pool[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    // Idle cycles before the next command word. Most gaps are short, a few
    // are long, and now and then a stretch of words follows with no gap.
    function automatic int next_gap();
        int roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            steady_left = $urandom_range(10, 30);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 20);
        return $urandom_range(21, 60);
    endfunction

    // The stimulus plan, and the end of the run.
    initial begin
        int  roll;
        int  ins_share;
        int  del_share;
        bit  growing;
        planned_list.len = 0;
        tracked_list.len = 0;
        for (int i = 0; i < DEPTH; i++) begin
            planned_list.vals[i] = '0;
            tracked_list.vals[i] = '0;
        end
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = $urandom;

        // Directed part. The empty list comes first: both lookups miss, and
        // an insert at position zero or past the end is refused.
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 5'd0);
        queue_cmd(CMD_DELETE, 32'h0000_0000, 5'd0);
        queue_cmd(CMD_INSERT, 32'h1234_5678, 5'd0);
        queue_cmd(CMD_INSERT, 32'h1234_5678, 5'd2);
        // Inserts at the head, at the tail and in the middle, with the
        // extreme values of the field.
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 5'd1);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 5'd1);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd3);
        queue_cmd(CMD_INSERT, 32'h0000_0000, 5'd2);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 5'd5);
        // Two matches, then the spare command code and the largest position.
        queue_cmd(CMD_SEARCH, 32'h8000_0000, 5'd0);
        queue_cmd(CMD_UNUSED, 32'h8000_0000, 5'd31);
        queue_cmd(CMD_INSERT, 32'h5555_AAAA, 5'd31);
        // Delete takes only the first of the two matches.
        queue_cmd(CMD_DELETE, 32'h8000_0000, 5'd0);
        queue_cmd(CMD_DELETE, 32'h0001_2345, 5'd0);
        // Fill the list with zeros, try one insert too many, search a list
        // that is nearly all matches, and delete near the tail of a full list.
        while (planned_list.len < DEPTH) queue_cmd(CMD_INSERT, 32'h0000_0000, 5'd1);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 5'd1);
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 5'd0);
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF, 5'd0);

        // Random part. Most words are well formed. The mix leans toward
        // inserts until the list is full and toward deletes until it is
        // empty, so both ends are reached again and again.
        growing = 1'b0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (planned_list.len == DEPTH) growing = 1'b0;
            else if (planned_list.len == 0) growing = 1'b1;
            ins_share = growing ? 55 : 20;
            del_share = growing ? 15 : 50;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                // Noise: the spare code, bad positions, or a word of random bits.
                case ($urandom_range(0, 3))
                    0: queue_cmd(CMD_UNUSED, $urandom, 5'($urandom_range(0, 31)));
                    1: queue_cmd(CMD_INSERT, pick_value(), 5'd0);
                    2: queue_cmd(CMD_INSERT, pick_value(),
                                 5'($urandom_range(planned_list.len + 2, 31)));
                    default: queue_cmd(2'($urandom_range(0, 3)), $urandom,
                                       5'($urandom_range(0, 31)));
                endcase
            end else if (roll < 12 + ins_share) begin
                queue_cmd(CMD_INSERT, pick_value(),
                          5'($urandom_range(1, planned_list.len + 1)));
            end else if (roll < 12 + ins_share + del_share) begin
                queue_cmd(CMD_DELETE, pick_value(), 5'($urandom_range(0, 31)));
            end else begin
                queue_cmd(CMD_SEARCH, pick_value(), 5'($urandom_range(0, 31)));
            end
        end

        // Wait until every word is taken and answered, then let the core
        // settle so that a stray result word would still be caught.
        while (!i_rst_n || items_accepted < items_total || awaited_answers.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Driver. A command word stays on the port with start high until the
    // core takes it, which happens at an edge where busy is low. The
    // answers for a word are predicted at the edge that takes it.
    always @(posedge i_clk) begin
        t_res_word new_words [$];
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_list_command(tracked_list, i_cmd, new_words);
                foreach (new_words[k]) awaited_answers.push_back(new_words[k]);
                items_accepted++;
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (queued_cmds.size() > 0) begin
                    i_cmd <= queued_cmds.pop_front();
                    start <= 1'b1;
                    idle_left = next_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every strobed result word is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        t_res_word want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (awaited_answers.size() == 0) begin
                $error("result word with none awaited: status %0d position_res %0d",
                       o_res.status, o_res.position_res);
                mismatch_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    mismatch_count++;
                end
                if (o_res.position_res !== want.position_res) begin
                    $error("position_res: expected %0d, got %0d",
                           want.position_res, o_res.position_res);
                    mismatch_count++;
                end
                if (o_res.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_res.length);
                    mismatch_count++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_res.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a run that hangs, for example on a core that never drops busy.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
